[sv/tbc_pkg.sv]
// Package for the tilt band classifier: field widths, band and mode codes, register indexes and reset values.
`timescale 1ns / 1ps

package tbc_pkg;

	localparam int AccelWidth = 16;
	localparam int LimitWidth = 16;
	localparam int CountWidth = 16;
	localparam int ModeWidth  = 3;
	localparam int BandWidth  = 2;
	localparam int CfgIdxWidth = 3;

	// Packed stream widths, rounded up to whole bytes
	localparam int InDataWidth  = 48;
	localparam int OutDataWidth = 24;

	typedef logic [BandWidth-1:0]  band_t;
	typedef logic [ModeWidth-1:0]  mode_t;
	typedef logic [CountWidth-1:0] count_t;
	typedef logic [LimitWidth-1:0] limit_t;

	// Band and reported mode codes
	localparam band_t BAND_LOW   = 2'd0;
	localparam band_t BAND_MID   = 2'd1;
	localparam band_t BAND_HIGH  = 2'd2;
	localparam band_t BAND_UNCAL = 2'd3;
	localparam mode_t MODE_HOT   = 3'd4;

	// Configuration register indexes
	localparam logic [CfgIdxWidth-1:0] REG_ENTER_MID  = 3'd0;
	localparam logic [CfgIdxWidth-1:0] REG_UPPER      = 3'd1;
	localparam logic [CfgIdxWidth-1:0] REG_RETURN_LOW = 3'd2;
	localparam logic [CfgIdxWidth-1:0] REG_LEAVE_HIGH = 3'd3;
	localparam logic [CfgIdxWidth-1:0] REG_DEBOUNCE   = 3'd4;
	localparam logic [CfgIdxWidth-1:0] REG_CALIBRATED = 3'd5;

	// Register reset values
	localparam limit_t ENTER_MID_RST  = 16'd1143;
	localparam limit_t UPPER_RST      = 16'd2845;
	localparam limit_t RETURN_LOW_RST = 16'd1086;
	localparam limit_t LEAVE_HIGH_RST = 16'd2139;
	localparam count_t DEBOUNCE_RST   = 16'd5;

endpackage

[sv/tilt_band_classifier_unit.sv]
// Tilt band classifier: hysteresis band selection with debounce on accelerometer samples.
`timescale 1ns / 1ps
// The result reaches the master side through the input register, then the band update
// into the result register.
// Throughput: one sample per cycle unless the result side stalls (m_tready low).
// Reset (arst_n low): band low, candidate mid, counter zero, registers at their defaults,
// both stage registers empty.
module tilt_band_classifier_unit (
	input  logic clk,
	input  logic arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [tbc_pkg::CfgIdxWidth-1:0]     cfg_index,
	input  logic [tbc_pkg::LimitWidth-1:0]      cfg_data,
	// sample stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tbc_pkg::InDataWidth-1:0]     s_tdata,  // accel_x, accel_y, accel_z
	input  logic                                s_tuser,  // overheat
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tbc_pkg::OutDataWidth-1:0]    m_tdata   // mode, pending_mode, agree_count, pad
);

	// Configuration registers
	tbc_pkg::limit_t enter_mid_q, upper_q, return_low_q, leave_high_q;
	tbc_pkg::count_t debounce_q;
	logic            calibrated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_mid_q  <= tbc_pkg::ENTER_MID_RST;
			upper_q      <= tbc_pkg::UPPER_RST;
			return_low_q <= tbc_pkg::RETURN_LOW_RST;
			leave_high_q <= tbc_pkg::LEAVE_HIGH_RST;
			debounce_q   <= tbc_pkg::DEBOUNCE_RST;
			calibrated_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tbc_pkg::REG_ENTER_MID:  enter_mid_q  <= cfg_data;
				tbc_pkg::REG_UPPER:      upper_q      <= cfg_data;
				tbc_pkg::REG_RETURN_LOW: return_low_q <= cfg_data;
				tbc_pkg::REG_LEAVE_HIGH: leave_high_q <= cfg_data;
				tbc_pkg::REG_DEBOUNCE:   debounce_q   <= cfg_data;
				tbc_pkg::REG_CALIBRATED: calibrated_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage 1: input register
	logic                                valid_s1;
	logic signed [tbc_pkg::AccelWidth-1:0] x_s1, y_s1, z_s1;
	logic                                hot_s1;
	logic                                valid_s2;
	logic                                advance;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			x_s1   <= s_tdata[15:0];
			y_s1   <= s_tdata[31:16];
			z_s1   <= s_tdata[47:32];
			hot_s1 <= s_tuser;
		end
	end

	// Tilt measure: larger magnitude of y and z, exact for the most negative value
	tbc_pkg::limit_t mag_y, mag_z, tilt;
	logic            upright;

	assign mag_y   = y_s1[15] ? (~y_s1 + 16'd1) : y_s1;
	assign mag_z   = z_s1[15] ? (~z_s1 + 16'd1) : z_s1;
	assign tilt    = (mag_y > mag_z) ? mag_y : mag_z;
	assign upright = !x_s1[15] && (x_s1 != '0);

	// Band state
	tbc_pkg::band_t  cur_q, cand_q;
	tbc_pkg::count_t cnt_q;

	// Target band from the current band's thresholds
	tbc_pkg::band_t target;
	always_comb begin
		case (cur_q)
			tbc_pkg::BAND_LOW: begin
				if (!upright)                target = tbc_pkg::BAND_HIGH;
				else if (tilt < enter_mid_q) target = tbc_pkg::BAND_LOW;
				else if (tilt < upper_q)     target = tbc_pkg::BAND_MID;
				else                         target = tbc_pkg::BAND_HIGH;
			end
			tbc_pkg::BAND_MID: begin
				if (!upright)                 target = tbc_pkg::BAND_HIGH;
				else if (tilt < return_low_q) target = tbc_pkg::BAND_LOW;
				else if (tilt < upper_q)      target = tbc_pkg::BAND_MID;
				else                          target = tbc_pkg::BAND_HIGH;
			end
			tbc_pkg::BAND_HIGH: begin
				if (!upright)                 target = tbc_pkg::BAND_HIGH;
				else if (tilt < return_low_q) target = tbc_pkg::BAND_LOW;
				else if (tilt < leave_high_q) target = tbc_pkg::BAND_MID;
				else                          target = tbc_pkg::BAND_HIGH;
			end
			default: target = tbc_pkg::BAND_MID;
		endcase
	end

	// Debounce and next state
	tbc_pkg::band_t  cur_d, cand_d;
	tbc_pkg::count_t cnt_d, cnt_inc;
	tbc_pkg::mode_t  shown;

	assign cnt_inc = cnt_q + 16'd1;

	always_comb begin
		cur_d  = cur_q;
		cand_d = cand_q;
		cnt_d  = cnt_q;
		if (hot_s1) begin
			shown = tbc_pkg::MODE_HOT;
		end else if (!calibrated_q) begin
			cur_d = tbc_pkg::BAND_UNCAL;
			shown = {1'b0, tbc_pkg::BAND_UNCAL};
		end else begin
			if (target != cur_q) begin
				if (target == cand_q) begin
					if (cnt_inc >= debounce_q) begin
						cur_d = target;
						cnt_d = '0;
					end else begin
						cnt_d = cnt_inc;
					end
				end else begin
					cand_d = target;
					cnt_d  = 16'd1;
				end
			end else begin
				cnt_d  = '0;
				cand_d = cur_q;
			end
			shown = {1'b0, cur_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= tbc_pkg::BAND_LOW;
			cand_q <= tbc_pkg::BAND_MID;
			cnt_q  <= '0;
		end else if (valid_s1 && advance) begin
			cur_q  <= cur_d;
			cand_q <= cand_d;
			cnt_q  <= cnt_d;
		end
	end

	// Stage 2: result register
	tbc_pkg::mode_t  mode_s2;
	tbc_pkg::band_t  pend_s2;
	tbc_pkg::count_t agree_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			mode_s2  <= shown;
			pend_s2  <= cand_d;
			agree_s2 <= cnt_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, agree_s2, pend_s2, mode_s2};

	// Checks
	a_count_needs_other_cand: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (cand_q != cur_q))
		else $error("nonzero agree count while candidate equals current band");

	a_cand_never_uncal: assert property (@(posedge clk) disable iff (!arst_n)
		cand_q != tbc_pkg::BAND_UNCAL)
		else $error("candidate band holds the uncalibrated code");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> valid_s2)
		else $error("sample left stage 1 without reaching the result register");

	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(cnt_q) && $stable(cur_q)))
		else $error("band state moved while stage 1 was stalled");

endmodule

[dv/tb.sv]
// Testbench for the tilt band classifier: directed and random samples against a band predictor.
`timescale 1ns / 1ps

module tb;

	localparam int WatchdogLimit = 3000;

	typedef struct packed {
		tbc_pkg::mode_t  mode;
		tbc_pkg::band_t  pend;
		tbc_pkg::count_t agree;
	} tilt_result_t;

	// Band predictor and store of expected results
	class tilt_scoreboard;
		tbc_pkg::limit_t enter_mid, upper, return_low, leave_high;
		tbc_pkg::count_t debounce;
		bit     calib;
		tbc_pkg::band_t  band, cand;
		tbc_pkg::count_t agree;
		tilt_result_t expected_q[$];
		int mismatches;
		int results_seen;

		function new();
			enter_mid    = tbc_pkg::ENTER_MID_RST;
			upper        = tbc_pkg::UPPER_RST;
			return_low   = tbc_pkg::RETURN_LOW_RST;
			leave_high   = tbc_pkg::LEAVE_HIGH_RST;
			debounce     = tbc_pkg::DEBOUNCE_RST;
			calib        = 1'b0;
			band         = tbc_pkg::BAND_LOW;
			cand         = tbc_pkg::BAND_MID;
			agree        = '0;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void set_reg(logic [tbc_pkg::CfgIdxWidth-1:0] idx, tbc_pkg::limit_t data);
			case (idx)
				tbc_pkg::REG_ENTER_MID:  enter_mid  = data;
				tbc_pkg::REG_UPPER:      upper      = data;
				tbc_pkg::REG_RETURN_LOW: return_low = data;
				tbc_pkg::REG_LEAVE_HIGH: leave_high = data;
				tbc_pkg::REG_DEBOUNCE:   debounce   = data;
				tbc_pkg::REG_CALIBRATED: calib      = data[0];
				default: ;
			endcase
		endfunction

		// Hysteresis: the current band selects which limits apply
		function tbc_pkg::band_t target_band(bit upright, int tilt);
			case (band)
				tbc_pkg::BAND_LOW: begin
					if (!upright) return tbc_pkg::BAND_HIGH;
					if (tilt < int'(enter_mid)) return tbc_pkg::BAND_LOW;
					if (tilt < int'(upper)) return tbc_pkg::BAND_MID;
					return tbc_pkg::BAND_HIGH;
				end
				tbc_pkg::BAND_MID: begin
					if (!upright) return tbc_pkg::BAND_HIGH;
					if (tilt < int'(return_low)) return tbc_pkg::BAND_LOW;
					if (tilt < int'(upper)) return tbc_pkg::BAND_MID;
					return tbc_pkg::BAND_HIGH;
				end
				tbc_pkg::BAND_HIGH: begin
					if (!upright) return tbc_pkg::BAND_HIGH;
					if (tilt < int'(return_low)) return tbc_pkg::BAND_LOW;
					if (tilt < int'(leave_high)) return tbc_pkg::BAND_MID;
					return tbc_pkg::BAND_HIGH;
				end
				default: return tbc_pkg::BAND_MID;
			endcase
		endfunction

		// Accepted sample: update band state and queue the result it causes
		function void note_sample(logic [tbc_pkg::AccelWidth-1:0] x, y, z, bit hot);
			int ay, az, tilt;
			tbc_pkg::band_t tgt;
			tilt_result_t r;
			if (hot) begin
				r.mode = tbc_pkg::MODE_HOT;
			end else if (!calib) begin
				band = tbc_pkg::BAND_UNCAL;
				r.mode = {1'b0, band};
			end else begin
				ay = $signed(y);
				az = $signed(z);
				if (ay < 0) ay = -ay;
				if (az < 0) az = -az;
				tilt = (ay > az) ? ay : az;
				tgt = target_band($signed(x) > 0, tilt);
				if (tgt != band) begin
					if (tgt == cand) begin
						agree = agree + 1'b1;
						if (agree >= debounce) begin
							band = tgt;
							agree = '0;
						end
					end else begin
						cand = tgt;
						agree = 16'd1;
					end
				end else begin
					agree = '0;
					cand = band;
				end
				r.mode = {1'b0, band};
			end
			r.pend = cand;
			r.agree = agree;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [tbc_pkg::OutDataWidth-1:0] data);
			tilt_result_t exp_r, got;
			got.mode  = data[2:0];
			got.pend  = data[4:3];
			got.agree = data[20:5];
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: mode %0d pend %0d count %0d",
						got.mode, got.pend, got.agree);
				return;
			end
			exp_r = expected_q.pop_front();
			if (got !== exp_r) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch @%0t: expected mode %0d pend %0d count %0d, ",
						"got mode %0d pend %0d count %0d"},
						$realtime, exp_r.mode, exp_r.pend, exp_r.agree,
						got.mode, got.pend, got.agree);
			end
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [tbc_pkg::CfgIdxWidth-1:0]  cfg_index = '0;
	logic [tbc_pkg::LimitWidth-1:0]   cfg_data = '0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [tbc_pkg::InDataWidth-1:0]  s_tdata = '0;  // accel_x, accel_y, accel_z
	logic                             s_tuser = 1'b0;  // overheat
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [tbc_pkg::OutDataWidth-1:0] m_tdata;  // mode, pending_mode, agree_count, pad

	tilt_scoreboard sb = new();

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;
	int items_sent = 0;
	int settings_used = 0;

	always #5 clk = ~clk;

	tilt_band_classifier_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Receiver: long hold-off when requested, else random stalls
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles = hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Monitor: check results, then note accepted samples
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (s_tvalid && s_tready)
			sb.note_sample(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tuser);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Watchdog on a stuck handshake
	initial begin
		wait (quiet_cycles >= WatchdogLimit);
		$display("watchdog: no transfer for %0d cycles", WatchdogLimit);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_sample(input logic [15:0] x, y, z, input bit hot);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {z, y, x};
		s_tuser  <= hot;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Stop offering and wait until every expected result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.expected_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [tbc_pkg::CfgIdxWidth-1:0] idx,
		input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting(input int em, up, rl, lh, deb, input bit cal);
		drain();
		write_reg(tbc_pkg::REG_ENTER_MID, 16'(em));
		write_reg(tbc_pkg::REG_UPPER, 16'(up));
		write_reg(tbc_pkg::REG_RETURN_LOW, 16'(rl));
		write_reg(tbc_pkg::REG_LEAVE_HIGH, 16'(lh));
		write_reg(tbc_pkg::REG_DEBOUNCE, 16'(deb));
		write_reg(tbc_pkg::REG_CALIBRATED, {15'($urandom_range(16'h7fff)), cal});
		settings_used++;
	endtask

	function automatic logic [15:0] to_axis(int mag, bit neg);
		if (mag >= 32768) return 16'h8000;
		return neg ? 16'(-mag) : 16'(mag);
	endfunction

	// Tilt near one of the active limits, near either end of the range, or anywhere in range
	function automatic int pick_tilt();
		int base;
		case ($urandom_range(5))
			0: base = sb.enter_mid;
			1: base = sb.upper;
			2: base = sb.return_low;
			3: base = sb.leave_high;
			4: return $urandom_range(32768);
			default: return $urandom_range(1) ? $urandom_range(40) : 32768 - $urandom_range(40);
		endcase
		base = base + $urandom_range(6) - 3;
		if (base < 0) base = 0;
		if (base > 32768) base = 32768;
		return base;
	endfunction

	// Runs of samples that aim at one band, so debouncing can complete for small debounce settings; some noise mixed in
	task automatic run_random(input int count);
		int left, run_len, run_max, t;
		logic [15:0] x, y, z, a, b;
		bit hot;
		left = count;
		while (left > 0) begin
			run_max = (sb.debounce > 9) ? 12 : sb.debounce + 3;
			run_len = $urandom_range(1, run_max);
			t = pick_tilt();
			while (run_len > 0 && left > 0) begin
				if ($urandom_range(99) < 85)
					x = 16'($urandom_range(1, 32767));
				else case ($urandom_range(2))
					0: x = 16'h0000;
					1: x = 16'h8000;
					default: x = 16'(-int'($urandom_range(1, 32767)));
				endcase
				a = to_axis(t, 1'($urandom_range(1)));
				b = to_axis($urandom_range(t), 1'($urandom_range(1)));
				if ($urandom_range(1)) begin
					y = a;
					z = b;
				end else begin
					y = b;
					z = a;
				end
				if ($urandom_range(99) < 10) begin
					x = 16'($urandom);
					y = 16'($urandom);
					z = 16'($urandom);
				end
				hot = ($urandom_range(99) < 4);
				send_sample(x, y, z, hot);
				run_len--;
				left--;
			end
		end
	endtask

	task automatic set_idling(input int pattern);
		case (pattern)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 75; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 75; end
			default: begin send_idle_pct = 7; stall_pct = 7; end
		endcase
	endtask

	initial begin
		int rl, em, lh, up;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: uncalibrated and overheat straight after reset
		send_sample(16'd100, 16'd0, 16'd0, 1'b0);
		send_sample(16'd100, 16'h8000, 16'd0, 1'b1);
		apply_setting(tbc_pkg::ENTER_MID_RST, tbc_pkg::UPPER_RST, tbc_pkg::RETURN_LOW_RST,
			tbc_pkg::LEAVE_HIGH_RST, 2, 1'b1);
		// leaving uncalibrated always aims at mid band
		send_sample(16'd500, 16'd0, 16'd0, 1'b0);
		send_sample(16'd500, 16'd0, 16'd0, 1'b0);
		// extremes: exact magnitude of the most negative value, not upright
		send_sample(16'h7fff, 16'h8000, 16'd0, 1'b0);
		send_sample(16'd0, 16'd0, 16'd0, 1'b0);
		send_sample(16'h8000, 16'd0, 16'h7fff, 1'b0);
		send_sample(16'h7fff, 16'h8000, 16'h8000, 1'b1);
		// tilt right at each limit
		send_sample(16'd1, 16'd2138, 16'd0, 1'b0);
		send_sample(16'd1, 16'd0, 16'd2139, 1'b0);
		send_sample(16'd1, 16'd1085, 16'd0, 1'b0);
		send_sample(16'd1, 16'd1086, 16'd0, 1'b0);
		send_sample(16'd1, 16'd0, 16'd1086, 1'b0);
		send_sample(16'd1, 16'd1142, 16'd0, 1'b0);
		send_sample(16'd1, 16'd1143, 16'd0, 1'b0);
		send_sample(16'd1, 16'd2844, 16'd0, 1'b0);
		send_sample(16'd1, 16'd0, -16'sd2845, 1'b0);
		send_sample(16'd1, -16'sd2845, 16'd0, 1'b0);
		// debounce of zero and of one both switch on the second agreeing sample
		apply_setting(tbc_pkg::ENTER_MID_RST, tbc_pkg::UPPER_RST, tbc_pkg::RETURN_LOW_RST,
			tbc_pkg::LEAVE_HIGH_RST, 0, 1'b1);
		send_sample(16'd1, 16'd0, 16'd0, 1'b0);
		send_sample(16'd1, 16'd0, 16'd0, 1'b0);
		apply_setting(tbc_pkg::ENTER_MID_RST, tbc_pkg::UPPER_RST, tbc_pkg::RETURN_LOW_RST,
			tbc_pkg::LEAVE_HIGH_RST, 1, 1'b1);
		send_sample(16'h8000, 16'd0, 16'd0, 1'b0);
		send_sample(16'h8000, 16'd0, 16'd0, 1'b0);

		// Random phases over several settings and idling patterns
		apply_setting(tbc_pkg::ENTER_MID_RST, tbc_pkg::UPPER_RST, tbc_pkg::RETURN_LOW_RST,
			tbc_pkg::LEAVE_HIGH_RST, 3, 1'b1);
		set_idling(0);
		run_random(90);

		rl = $urandom_range(8000);
		em = rl + $urandom_range(500);
		lh = em + $urandom_range(6000);
		up = lh + $urandom_range(8000);
		apply_setting(em, up, rl, lh, 1, 1'b1);
		set_idling(1);
		run_random(90);

		// long receiver hold-off while the sender keeps offering
		rl = $urandom_range(8000);
		em = rl + $urandom_range(500);
		lh = em + $urandom_range(6000);
		up = lh + $urandom_range(8000);
		apply_setting(em, up, rl, lh, 0, 1'b1);
		set_idling(2);
		hold_cycles = 80;
		run_random(90);

		apply_setting(32768, 32768, 32768, 32768, 2, 1'b1);
		set_idling(3);
		run_random(90);

		// sender pauses mid-phase until everything has drained
		apply_setting(0, 0, 0, 0, 4, 1'b1);
		set_idling(0);
		run_random(45);
		drain();
		run_random(45);

		// unordered limits
		apply_setting($urandom_range(32768), $urandom_range(32768), $urandom_range(32768),
			$urandom_range(32768), $urandom_range(1, 6), 1'b1);
		set_idling(1);
		run_random(90);

		apply_setting(tbc_pkg::ENTER_MID_RST, tbc_pkg::UPPER_RST, tbc_pkg::RETURN_LOW_RST,
			tbc_pkg::LEAVE_HIGH_RST, 3, 1'b0);
		set_idling(2);
		run_random(40);

		apply_setting(tbc_pkg::ENTER_MID_RST, tbc_pkg::UPPER_RST, tbc_pkg::RETURN_LOW_RST,
			tbc_pkg::LEAVE_HIGH_RST, 65535, 1'b1);
		set_idling(3);
		run_random(60);

		rl = $urandom_range(8000);
		em = rl + $urandom_range(500);
		lh = em + $urandom_range(6000);
		up = lh + $urandom_range(8000);
		apply_setting(em, up, rl, lh, $urandom_range(2, 8), 1'b1);
		set_idling(3);
		hold_cycles = 60;
		run_random(100);

		drain();
		repeat (4) @(negedge clk);

		$display("run: %0d samples sent, %0d results checked, %0d mismatches",
			items_sent, sb.results_seen, sb.mismatches);
		$display("covered %0d register settings, four idling patterns, hold-off and drain pauses",
			settings_used);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d results never arrived", sb.expected_q.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
sv/tbc_pkg.sv
sv/tilt_band_classifier_unit.sv
dv/tb.sv
